/* sv/qs_pkg.sv */
// ----------------------------------------------------------------------------
// qs_pkg: shared constants, types and tables for quaternion slerp
// Fixed-point formats, CORDIC arctangent table and the item tag that travels
// alongside the arithmetic through the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qs_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int QW           = 16;              // quaternion component width
  localparam int WGT_W        = 15;              // weight / threshold width
  localparam int ANG_BITS     = 30;
  localparam int UP           = ANG_BITS - FRAC_BITS;
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 34;              // CORDIC datapath width
  localparam int INV_GAIN     = 652032874;
  localparam int C_W          = FRAC_BITS;       // cosine width on the spherical path
  localparam int SQ_W         = FRAC_BITS + 1;   // sqrt result width
  localparam int N_W          = 2 * FRAC_BITS + 2;
  localparam int NUM_W        = CW + FRAC_BITS;  // divider numerator width
  localparam int KW           = 34;              // weight k, Q30, +-2^32
  localparam int PW           = 52;              // component * k product
  localparam int DOT_W        = 35;
  localparam int PROD_W       = 2 * QW + 1;
  localparam logic [WGT_W-1:0] THR_RESET = 15'd16376;

  typedef struct packed {
    logic [3:0][QW-1:0] s;
    logic [3:0][QW:0]   e;
    logic [WGT_W-1:0]   t;
    logic               lerp;
    logic [SQ_W-1:0]    sina;
    logic [1:0]         neg;
  } tag_t;

  function automatic logic [CW-1:0] atan_q30(input int i);
    logic [CW-1:0] v;
    case (i)
      0:  v = 34'd843314856;
      1:  v = 34'd497837829;
      2:  v = 34'd263043836;
      3:  v = 34'd133525158;
      4:  v = 34'd67021686;
      5:  v = 34'd33543515;
      6:  v = 34'd16775850;
      7:  v = 34'd8388437;
      8:  v = 34'd4194282;
      9:  v = 34'd2097149;
      10: v = 34'd1048575;
      11: v = 34'd524287;
      12: v = 34'd262143;
      13: v = 34'd131072;
      14: v = 34'd65536;
      15: v = 34'd32768;
      16: v = 34'd16384;
      17: v = 34'd8192;
      18: v = 34'd4096;
      19: v = 34'd2048;
      20: v = 34'd1024;
      21: v = 34'd512;
      22: v = 34'd256;
      23: v = 34'd128;
      24: v = 34'd64;
      25: v = 34'd32;
      26: v = 34'd16;
      27: v = 34'd8;
      28: v = 34'd4;
      29: v = 34'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/qs_cordic.sv */
// ----------------------------------------------------------------------------
// qs_cordic: pipelined CORDIC, one micro-rotation per stage
// Vectoring mode accumulates the angle of (x, y); rotation mode drives z to
// zero and yields the sine in y. Several lanes share the stage control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qs_cordic #(
  parameter int LANES  = 1,
  parameter bit VECTOR = 1'b0,
  parameter int STEPS  = qs_pkg::CORDIC_STEPS,
  parameter int TW     = 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [TW-1:0]                       in_tag,
  input  logic [LANES-1:0][qs_pkg::CW-1:0]    in_x,
  input  logic [LANES-1:0][qs_pkg::CW-1:0]    in_y,
  input  logic [LANES-1:0][qs_pkg::CW-1:0]    in_z,
  output logic                                out_valid,
  output logic [TW-1:0]                       out_tag,
  output logic [LANES-1:0][qs_pkg::CW-1:0]    out_y,
  output logic [LANES-1:0][qs_pkg::CW-1:0]    out_z
);
  import qs_pkg::*;

  logic                      vld [STEPS];
  logic [TW-1:0]             tg  [STEPS];
  logic [LANES-1:0][CW-1:0]  xs  [STEPS];
  logic [LANES-1:0][CW-1:0]  ys  [STEPS];
  logic [LANES-1:0][CW-1:0]  zs  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                     pv;
    logic [TW-1:0]            pt;
    logic [LANES-1:0][CW-1:0] px, py, pz, nx, ny, nz;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pt = in_tag;
      assign px = in_x;
      assign py = in_y;
      assign pz = in_z;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pt = tg[k-1];
      assign px = xs[k-1];
      assign py = ys[k-1];
      assign pz = zs[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (VECTOR ? ($signed(py[l]) > 0) : ($signed(pz[l]) < 0)) begin
          nx[l] = px[l] + CW'($signed(py[l]) >>> k);
          ny[l] = py[l] - CW'($signed(px[l]) >>> k);
          nz[l] = pz[l] + atan_q30(k);
        end else begin
          nx[l] = px[l] - CW'($signed(py[l]) >>> k);
          ny[l] = py[l] + CW'($signed(px[l]) >>> k);
          nz[l] = pz[l] - atan_q30(k);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tg[k] <= pt;
        xs[k] <= nx;
        ys[k] <= ny;
        zs[k] <= nz;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_tag   = tg[STEPS-1];
  assign out_y     = ys[STEPS-1];
  assign out_z     = zs[STEPS-1];

endmodule

`default_nettype wire

/* sv/qs_div.sv */
// ----------------------------------------------------------------------------
// qs_div: pipelined restoring divider, one quotient bit per stage
// Unsigned numerators in several lanes over one shared divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qs_div #(
  parameter int LANES = 2,
  parameter int NW    = qs_pkg::NUM_W,
  parameter int DW    = qs_pkg::SQ_W,
  parameter int TW    = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [TW-1:0]             in_tag,
  input  logic [LANES-1:0][NW-1:0]  in_num,
  input  logic [DW-1:0]             in_den,
  output logic                      out_valid,
  output logic [TW-1:0]             out_tag,
  output logic [LANES-1:0][NW-1:0]  out_q
);

  logic                     vld [NW];
  logic [TW-1:0]            tg  [NW];
  logic [DW-1:0]            den [NW];
  logic [LANES-1:0][DW-1:0] rem [NW];
  logic [LANES-1:0][NW-1:0] nq  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic                     pv;
    logic [TW-1:0]            pt;
    logic [DW-1:0]            pd;
    logic [LANES-1:0][DW-1:0] pr, nr;
    logic [LANES-1:0][NW-1:0] pq, nqn;
    logic [LANES-1:0][DW:0]   r2;

    if (k == 0) begin : g_first
      assign pv = in_valid;
      assign pt = in_tag;
      assign pd = in_den;
      assign pr = '0;
      assign pq = in_num;
    end else begin : g_next
      assign pv = vld[k-1];
      assign pt = tg[k-1];
      assign pd = den[k-1];
      assign pr = rem[k-1];
      assign pq = nq[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r2[l] = {pr[l], pq[l][NW-1]};
        if (r2[l] >= {1'b0, pd}) begin
          nr[l]  = DW'(r2[l] - {1'b0, pd});
          nqn[l] = {pq[l][NW-2:0], 1'b1};
        end else begin
          nr[l]  = r2[l][DW-1:0];
          nqn[l] = {pq[l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tg[k]  <= pt;
        den[k] <= pd;
        rem[k] <= nr;
        nq[k]  <= nqn;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign out_tag   = tg[NW-1];
  assign out_q     = nq[NW-1];

endmodule

`default_nettype wire

/* sv/quaternion_slerp_top.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp_top: fixed-point quaternion slerp, fully pipelined
// Input beat: start and end quaternions, signed Q1.14, plus weight, unsigned Q1.14.
// Output beat: the interpolated quaternion, each component saturated to +-1.0.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// The config channel (cfg_valid/cfg_ready/cfg_data) writes lerp_threshold;
// cfg_ready is always high. Reset (rst, synchronous) empties the pipeline and
// sets the threshold to 16376.
// One beat is accepted every cycle while the pipeline is not stalled. Stages in
// order: dot product and setup, square root (one root bit per stage), CORDIC
// vectoring, angle scaling, CORDIC rotation (both sines in parallel lanes),
// numerator setup, division (one quotient bit per stage) and weighting,
// rounding and saturation.
// When the receiver stalls a waiting result, the whole pipeline holds and
// item_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quaternion_slerp_top #(
  parameter int CORDIC_STEPS = qs_pkg::CORDIC_STEPS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [qs_pkg::QW-1:0]      start_w,
  input  logic signed [qs_pkg::QW-1:0]      start_x,
  input  logic signed [qs_pkg::QW-1:0]      start_y,
  input  logic signed [qs_pkg::QW-1:0]      start_z,
  input  logic signed [qs_pkg::QW-1:0]      end_w,
  input  logic signed [qs_pkg::QW-1:0]      end_x,
  input  logic signed [qs_pkg::QW-1:0]      end_y,
  input  logic signed [qs_pkg::QW-1:0]      end_z,
  input  logic        [qs_pkg::WGT_W-1:0]   weight,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [qs_pkg::QW-1:0]      res_w,
  output logic signed [qs_pkg::QW-1:0]      res_x,
  output logic signed [qs_pkg::QW-1:0]      res_y,
  output logic signed [qs_pkg::QW-1:0]      res_z,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic        [qs_pkg::WGT_W-1:0]   cfg_data
);
  import qs_pkg::*;

  localparam int TAG_W = $bits(tag_t);

  logic             en;
  logic [WGT_W-1:0] thr;

  assign en         = !res_valid || !res_stall;
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // input register
  logic a_valid;
  tag_t a_tag, a_tag_next;

  always_comb begin
    a_tag_next      = '0;
    a_tag_next.s    = {start_z, start_y, start_x, start_w};
    a_tag_next.e[0] = {end_w[QW-1], end_w};
    a_tag_next.e[1] = {end_x[QW-1], end_x};
    a_tag_next.e[2] = {end_y[QW-1], end_y};
    a_tag_next.e[3] = {end_z[QW-1], end_z};
    a_tag_next.t    = (weight > WGT_W'(ONE)) ? WGT_W'(ONE) : weight;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_tag <= a_tag_next;
    end
  end

  // component products
  logic                     b_valid;
  tag_t                     b_tag;
  logic signed [PROD_W-1:0] b_prod [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_tag <= a_tag;
      for (int j = 0; j < 4; j++) begin
        b_prod[j] <= $signed(a_tag.s[j]) * $signed(a_tag.e[j]);
      end
    end
  end

  // dot product, shorter arc, lerp decision
  logic                      c_valid;
  tag_t                      c_tag, c_tag_next;
  logic [C_W-1:0]            c_c;
  logic signed [DOT_W-1:0]   dot;
  logic [DOT_W-1:0]          dabs;
  logic [DOT_W-FRAC_BITS-1:0] cval;
  logic                      dneg;

  always_comb begin
    dot = '0;
    for (int j = 0; j < 4; j++) begin
      dot = dot + DOT_W'(b_prod[j]);
    end
    dneg = dot[DOT_W-1];
    dabs = dneg ? DOT_W'(-dot) : DOT_W'(dot);
    cval = dabs[DOT_W-1:FRAC_BITS];
    c_tag_next = b_tag;
    for (int j = 0; j < 4; j++) begin
      c_tag_next.e[j] = dneg ? (QW+1)'(-$signed(b_tag.e[j])) : b_tag.e[j];
    end
    c_tag_next.lerp = (cval > (DOT_W-FRAC_BITS)'(thr)) ||
                      (cval >= (DOT_W-FRAC_BITS)'(ONE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_tag <= c_tag_next;
      c_c   <= cval[C_W-1:0];
    end
  end

  // 1 - c^2
  logic           d_valid;
  tag_t           d_tag;
  logic [C_W-1:0] d_c;
  logic [N_W-1:0] d_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_tag <= c_tag;
      d_c   <= c_c;
      d_n   <= (N_W'(1) << (2 * FRAC_BITS)) - N_W'(c_c) * N_W'(c_c);
    end
  end

  // square root, one bit per stage
  logic            sq_valid [SQ_W];
  tag_t            sq_tag   [SQ_W];
  logic [C_W-1:0]  sq_c     [SQ_W];
  logic [SQ_W-1:0] sq_root  [SQ_W];
  logic [N_W-1:0]  sq_rem   [SQ_W];

  for (genvar k = 0; k < SQ_W; k++) begin : g_sq
    localparam int B = SQ_W - 1 - k;
    logic            pv;
    tag_t            pt;
    logic [C_W-1:0]  pc;
    logic [SQ_W-1:0] pr;
    logic [N_W-1:0]  pm, trial;

    if (k == 0) begin : g_first
      assign pv = d_valid;
      assign pt = d_tag;
      assign pc = d_c;
      assign pr = '0;
      assign pm = d_n;
    end else begin : g_next
      assign pv = sq_valid[k-1];
      assign pt = sq_tag[k-1];
      assign pc = sq_c[k-1];
      assign pr = sq_root[k-1];
      assign pm = sq_rem[k-1];
    end

    assign trial = (N_W'(pr) << (B + 1)) + (N_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k] <= 1'b0;
      end else if (en) begin
        sq_valid[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_tag[k] <= pt;
        sq_c[k]   <= pc;
        if (pm >= trial) begin
          sq_rem[k]  <= pm - trial;
          sq_root[k] <= pr | (SQ_W'(1) << B);
        end else begin
          sq_rem[k]  <= pm;
          sq_root[k] <= pr;
        end
      end
    end
  end

  // angle a = atan2(sin a, c)
  tag_t            v_in_tag;
  logic [SQ_W-1:0] sina;
  logic [0:0][CW-1:0] v_in_x, v_in_y, v_in_z, v_z;
  logic            v_valid;
  logic [TAG_W-1:0] v_tag_bits;
  tag_t            v_tag;

  always_comb begin
    sina          = (sq_root[SQ_W-1] == '0) ? SQ_W'(1) : sq_root[SQ_W-1];
    v_in_tag      = sq_tag[SQ_W-1];
    v_in_tag.sina = sina;
    v_in_x[0]     = CW'(sq_c[SQ_W-1]) << UP;
    v_in_y[0]     = CW'(sina) << UP;
    v_in_z[0]     = '0;
  end

  qs_cordic #(
    .LANES  (1),
    .VECTOR (1'b1),
    .STEPS  (CORDIC_STEPS),
    .TW     (TAG_W)
  ) u_vec (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid[SQ_W-1]),
    .in_tag    (v_in_tag),
    .in_x      (v_in_x),
    .in_y      (v_in_y),
    .in_z      (v_in_z),
    .out_valid (v_valid),
    .out_tag   (v_tag_bits),
    .out_y     (),
    .out_z     (v_z)
  );

  assign v_tag = tag_t'(v_tag_bits);

  // scaled angles (1-t)a and ta
  logic                    e_valid;
  tag_t                    e_tag;
  logic [1:0][CW-1:0]      e_ang;
  logic [WGT_W-1:0]        w0;
  logic signed [CW+QW-1:0] ap0, ap1;

  always_comb begin
    w0  = WGT_W'(ONE) - v_tag.t;
    ap0 = $signed(v_z[0]) * $signed({1'b0, w0});
    ap1 = $signed(v_z[0]) * $signed({1'b0, v_tag.t});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_tag    <= v_tag;
      e_ang[0] <= ap0[FRAC_BITS +: CW];
      e_ang[1] <= ap1[FRAC_BITS +: CW];
    end
  end

  // both sines
  logic [1:0][CW-1:0] r_in_x, r_in_y, r_y;
  logic               r_valid;
  logic [TAG_W-1:0]   r_tag_bits;
  tag_t               r_tag;

  assign r_in_x = {CW'(INV_GAIN), CW'(INV_GAIN)};
  assign r_in_y = '0;

  qs_cordic #(
    .LANES  (2),
    .VECTOR (1'b0),
    .STEPS  (CORDIC_STEPS),
    .TW     (TAG_W)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .in_tag    (e_tag),
    .in_x      (r_in_x),
    .in_y      (r_in_y),
    .in_z      (e_ang),
    .out_valid (r_valid),
    .out_tag   (r_tag_bits),
    .out_y     (r_y),
    .out_z     ()
  );

  assign r_tag = tag_t'(r_tag_bits);

  // divider numerators |sin| * ONE
  logic                  f_valid;
  tag_t                  f_tag, f_tag_next;
  logic [1:0][NUM_W-1:0] f_num, f_num_next;

  always_comb begin
    f_tag_next = r_tag;
    for (int l = 0; l < 2; l++) begin
      f_tag_next.neg[l] = r_y[l][CW-1];
      f_num_next[l] = {(r_y[l][CW-1] ? CW'(-$signed(r_y[l])) : r_y[l]),
                       {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_tag <= f_tag_next;
      f_num <= f_num_next;
    end
  end

  logic                  q_valid;
  logic [TAG_W-1:0]      q_tag_bits;
  tag_t                  q_tag;
  logic [1:0][NUM_W-1:0] q_val;

  qs_div #(
    .LANES (2),
    .NW    (NUM_W),
    .DW    (SQ_W),
    .TW    (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_tag    (f_tag),
    .in_num    (f_num),
    .in_den    (f_tag.sina),
    .out_valid (q_valid),
    .out_tag   (q_tag_bits),
    .out_q     (q_val)
  );

  assign q_tag = tag_t'(q_tag_bits);

  // weights k0, k1
  logic               g_valid;
  tag_t               g_tag;
  logic [1:0][KW-1:0] g_k, g_k_next;
  logic [1:0][KW-1:0] kmag;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      kmag[l] = (q_val[l] > (NUM_W'(1) << 32)) ? (KW'(1) << 32) : KW'(q_val[l]);
      g_k_next[l] = q_tag.neg[l] ? KW'(-kmag[l]) : kmag[l];
    end
    if (q_tag.lerp) begin
      g_k_next[0] = KW'(WGT_W'(ONE) - q_tag.t) << UP;
      g_k_next[1] = KW'(q_tag.t) << UP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_tag <= q_tag;
      g_k   <= g_k_next;
    end
  end

  // weighted products
  logic                 h_valid;
  logic signed [PW-1:0] h_ps [4];
  logic signed [PW-1:0] h_pe [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        h_ps[j] <= PW'($signed(g_tag.s[j])) * PW'($signed(g_k[0]));
        h_pe[j] <= PW'($signed(g_tag.e[j])) * PW'($signed(g_k[1]));
      end
    end
  end

  // round, saturate, output register
  logic signed [PW:0]          acc [4];
  logic signed [PW-ANG_BITS:0] rnd [4];
  logic [3:0][QW-1:0]          res_next;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc[j] = (PW+1)'(h_ps[j]) + (PW+1)'(h_pe[j]) + ((PW+1)'(1) << (ANG_BITS - 1));
      rnd[j] = acc[j][PW:ANG_BITS];
      if (rnd[j] > $signed((PW-ANG_BITS+1)'(ONE))) begin
        res_next[j] = QW'(ONE);
      end else if (rnd[j] < -$signed((PW-ANG_BITS+1)'(ONE))) begin
        res_next[j] = QW'(-ONE);
      end else begin
        res_next[j] = rnd[j][QW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_w <= res_next[0];
      res_x <= res_next[1];
      res_y <= res_next[2];
      res_z <= res_next[3];
    end
  end

  // checks
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ($signed(res_w) <= ONE && $signed(res_w) >= -ONE &&
                   $signed(res_x) <= ONE && $signed(res_x) >= -ONE &&
                   $signed(res_y) <= ONE && $signed(res_y) >= -ONE &&
                   $signed(res_z) <= ONE && $signed(res_z) >= -ONE))
    else $error("result component out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    f_valid |-> (f_tag.sina != '0))
    else $error("zero divisor entering divider");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (res_valid && res_stall))
    else $error("input stalled without a blocked result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> ($stable(g_k) && $stable(h_valid)))
    else $error("pipeline moved while output blocked");

endmodule

`default_nettype wire
